// ===== sv/sat_pkg.sv =====
`timescale 1ns / 1ps

package sat_pkg;

   localparam int CAPACITY_DEFAULT    = 16;
   localparam int KEY_WIDTH_DEFAULT   = 32;
   localparam int VALUE_WIDTH_DEFAULT = 32;

   localparam int CMD_FIELD_WIDTH    = 3;
   localparam int KEY_FIELD_WIDTH    = 32;
   localparam int VALUE_FIELD_WIDTH  = 32;
   localparam int POS_FIELD_WIDTH    = 4;
   localparam int STATUS_FIELD_WIDTH = 3;
   localparam int COUNT_FIELD_WIDTH  = 5;

   localparam logic [CMD_FIELD_WIDTH-1:0] CMD_INSERT  = 3'd0;
   localparam logic [CMD_FIELD_WIDTH-1:0] CMD_REMOVE  = 3'd1;
   localparam logic [CMD_FIELD_WIDTH-1:0] CMD_GET     = 3'd2;
   localparam logic [CMD_FIELD_WIDTH-1:0] CMD_CLEAR   = 3'd3;
   localparam logic [CMD_FIELD_WIDTH-1:0] CMD_READ_AT = 3'd4;

   typedef enum logic [STATUS_FIELD_WIDTH-1:0] {
      STATUS_FULL     = 3'd0,
      STATUS_REPLACED = 3'd1,
      STATUS_ADDED    = 3'd2,
      STATUS_HIT      = 3'd3,
      STATUS_MISS     = 3'd4,
      STATUS_CLEARED  = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      WR_NONE   = 2'd0,
      WR_MATCH  = 2'd1,
      WR_APPEND = 2'd2,
      WR_SHIFT  = 2'd3
   } wr_sel_type;

   typedef struct packed {
      logic [CMD_FIELD_WIDTH-1:0]   cmd;
      logic [KEY_FIELD_WIDTH-1:0]   key;
      logic [VALUE_FIELD_WIDTH-1:0] value;
      logic [POS_FIELD_WIDTH-1:0]   position;
   } req_word_type;

   typedef struct packed {
      logic [STATUS_FIELD_WIDTH-1:0] status;
      logic [KEY_FIELD_WIDTH-1:0]    key_out;
      logic [VALUE_FIELD_WIDTH-1:0]  value_out;
      logic [COUNT_FIELD_WIDTH-1:0]  entry_count;
   } rsp_word_type;

   typedef struct packed {
      logic       load;
      logic       scan_step;
      logic       shift_start;
      logic       rd_pos;
      wr_sel_type wr_sel;
      logic       count_inc;
      logic       count_dec;
      logic       count_clr;
      logic       res_load;
      logic       res_data;
      status_type res_status;
      logic       out_load;
   } ctl_cmd_type;

   typedef struct packed {
      logic [CMD_FIELD_WIDTH-1:0] cmd;
      logic                       full;
      logic                       pos_ok;
      logic                       hit;
      logic                       miss;
      logic                       pend;
      logic                       shift_done;
      logic                       out_free;
   } ctl_stat_type;

endpackage

// ===== sv/sat_ram.sv =====
`timescale 1ns / 1ps

module sat_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/sat_datapath.sv =====
`timescale 1ns / 1ps

module sat_datapath #(
   parameter int CAPACITY    = sat_pkg::CAPACITY_DEFAULT,
   parameter int KEY_WIDTH   = sat_pkg::KEY_WIDTH_DEFAULT,
   parameter int VALUE_WIDTH = sat_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  sat_pkg::req_word_type req_word,
   input  sat_pkg::ctl_cmd_type  ctl,
   output sat_pkg::ctl_stat_type stat,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output sat_pkg::rsp_word_type rsp_word
);

   localparam int AW     = $clog2(CAPACITY);
   localparam int CW     = $clog2(CAPACITY + 1);
   localparam int DW     = KEY_WIDTH + VALUE_WIDTH;
   localparam int KFW    = sat_pkg::KEY_FIELD_WIDTH;
   localparam int VFW    = sat_pkg::VALUE_FIELD_WIDTH;
   localparam int NFW    = sat_pkg::COUNT_FIELD_WIDTH;
   localparam int KEEP_K = (KEY_WIDTH < KFW) ? KEY_WIDTH : KFW;
   localparam int KEEP_V = (VALUE_WIDTH < VFW) ? VALUE_WIDTH : VFW;

   logic [sat_pkg::CMD_FIELD_WIDTH-1:0] cmd_ff, cmd_in;
   logic [KEY_WIDTH-1:0]                key_ff, key_in;
   logic [VALUE_WIDTH-1:0]              val_ff, val_in;
   logic [sat_pkg::POS_FIELD_WIDTH-1:0] pos_ff, pos_in;
   logic [CW-1:0]                       count_ff, count_in;
   logic [CW-1:0]                       idx_ff, idx_in;
   logic                                pend_ff, pend_in;
   logic [AW-1:0]                       pidx_ff, pidx_in;
   sat_pkg::status_type                 res_status_ff, res_status_in;
   logic [KFW-1:0]                      res_key_ff, res_key_in;
   logic [VFW-1:0]                      res_val_ff, res_val_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   sat_pkg::rsp_word_type               rsp_ff, rsp_in;

   logic                   more;
   logic                   out_free;
   logic [DW-1:0]          rd_data;
   logic [KEY_WIDTH-1:0]   rd_key;
   logic [VALUE_WIDTH-1:0] rd_val;
   logic                   ram_we;
   logic [AW-1:0]          ram_waddr;
   logic [DW-1:0]          ram_wdata;
   logic [AW-1:0]          ram_raddr;

   sat_ram #(
      .WIDTH (DW),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (rd_data)
   );

   always_comb begin
      more     = (idx_ff < count_ff);
      out_free = !rsp_valid_ff || !rsp_stall;
      rd_key   = rd_data[DW-1:VALUE_WIDTH];
      rd_val   = rd_data[VALUE_WIDTH-1:0];

      stat.cmd        = cmd_ff;
      stat.full       = (count_ff >= CW'(CAPACITY));
      stat.pos_ok     = (32'(pos_ff) < 32'(count_ff));
      stat.hit        = pend_ff && (rd_key == key_ff);
      stat.miss       = !more && !stat.hit;
      stat.pend       = pend_ff;
      stat.shift_done = !more && !pend_ff;
      stat.out_free   = out_free;

      if (ctl.rd_pos) begin
         ram_raddr = AW'(pos_ff);
      end else if (more) begin
         ram_raddr = idx_ff[AW-1:0];
      end else begin
         ram_raddr = '0;
      end

      ram_we    = 1'b0;
      ram_waddr = pidx_ff;
      ram_wdata = {key_ff, val_ff};
      case (ctl.wr_sel)
         sat_pkg::WR_MATCH: begin
            ram_we = 1'b1;
         end
         sat_pkg::WR_APPEND: begin
            ram_we    = 1'b1;
            ram_waddr = count_ff[AW-1:0];
         end
         sat_pkg::WR_SHIFT: begin
            ram_we    = 1'b1;
            ram_waddr = pidx_ff - AW'(1);
            ram_wdata = rd_data;
         end
         default: begin
            ram_we = 1'b0;
         end
      endcase

      cmd_in = cmd_ff;
      key_in = key_ff;
      val_in = val_ff;
      pos_in = pos_ff;
      if (ctl.load) begin
         cmd_in = req_word.cmd;
         key_in = KEY_WIDTH'(req_word.key[KEEP_K-1:0]);
         val_in = VALUE_WIDTH'(req_word.value[KEEP_V-1:0]);
         pos_in = req_word.position;
      end

      idx_in  = idx_ff;
      pend_in = pend_ff;
      pidx_in = pidx_ff;
      if (ctl.load) begin
         idx_in  = '0;
         pend_in = 1'b0;
      end else if (ctl.shift_start) begin
         idx_in  = CW'(pidx_ff) + CW'(1);
         pend_in = 1'b0;
      end else if (ctl.scan_step) begin
         pend_in = more;
         if (more) begin
            idx_in  = idx_ff + CW'(1);
            pidx_in = idx_ff[AW-1:0];
         end
      end

      count_in = count_ff;
      if (ctl.count_clr) begin
         count_in = '0;
      end else if (ctl.count_inc) begin
         count_in = count_ff + CW'(1);
      end else if (ctl.count_dec) begin
         count_in = count_ff - CW'(1);
      end

      res_status_in = res_status_ff;
      res_key_in    = res_key_ff;
      res_val_in    = res_val_ff;
      if (ctl.res_load) begin
         res_status_in = ctl.res_status;
         res_key_in    = ctl.res_data ? KFW'(rd_key[KEEP_K-1:0]) : '0;
         res_val_in    = ctl.res_data ? VFW'(rd_val[KEEP_V-1:0]) : '0;
      end

      rsp_in = rsp_ff;
      if (ctl.out_load) begin
         rsp_in.status      = res_status_ff;
         rsp_in.key_out     = res_key_ff;
         rsp_in.value_out   = res_val_ff;
         rsp_in.entry_count = NFW'(count_ff);
      end
      rsp_valid_in = ctl.out_load ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      val_ff        <= val_in;
      pos_ff        <= pos_in;
      idx_ff        <= idx_in;
      pidx_ff       <= pidx_in;
      res_status_ff <= res_status_in;
      res_key_ff    <= res_key_in;
      res_val_ff    <= res_val_in;
      rsp_ff        <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   a_shift_has_data: assert property (@(posedge clock) disable iff (reset)
      ctl.wr_sel == sat_pkg::WR_SHIFT |-> pend_ff)
      else $error("shift write without read data");

   a_out_load_free: assert property (@(posedge clock) disable iff (reset)
      ctl.out_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result overwritten while held");

endmodule

// ===== sv/sat_controller.sv =====
`timescale 1ns / 1ps

module sat_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  sat_pkg::ctl_stat_type stat,
   output sat_pkg::ctl_cmd_type  ctl
);

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_DECODE = 6'b000010,
      S_SCAN   = 6'b000100,
      S_SHIFT  = 6'b001000,
      S_READ   = 6'b010000,
      S_RESULT = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      ctl            = '0;
      ctl.wr_sel     = sat_pkg::WR_NONE;
      ctl.res_status = sat_pkg::STATUS_MISS;
      state_in       = state_ff;
      req_stall      = (state_ff != S_IDLE);

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctl.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            case (stat.cmd)
               sat_pkg::CMD_INSERT: begin
                  if (stat.full) begin
                     ctl.res_load   = 1'b1;
                     ctl.res_status = sat_pkg::STATUS_FULL;
                     state_in       = S_RESULT;
                  end else begin
                     state_in = S_SCAN;
                  end
               end
               sat_pkg::CMD_REMOVE, sat_pkg::CMD_GET: begin
                  state_in = S_SCAN;
               end
               sat_pkg::CMD_CLEAR: begin
                  ctl.count_clr  = 1'b1;
                  ctl.res_load   = 1'b1;
                  ctl.res_status = sat_pkg::STATUS_CLEARED;
                  state_in       = S_RESULT;
               end
               sat_pkg::CMD_READ_AT: begin
                  if (stat.pos_ok) begin
                     ctl.rd_pos = 1'b1;
                     state_in   = S_READ;
                  end else begin
                     ctl.res_load = 1'b1;
                     state_in     = S_RESULT;
                  end
               end
               default: begin
                  ctl.res_load = 1'b1;
                  state_in     = S_RESULT;
               end
            endcase
         end
         S_SCAN: begin
            if (stat.hit) begin
               ctl.res_load = 1'b1;
               case (stat.cmd)
                  sat_pkg::CMD_INSERT: begin
                     ctl.wr_sel     = sat_pkg::WR_MATCH;
                     ctl.res_status = sat_pkg::STATUS_REPLACED;
                     state_in       = S_RESULT;
                  end
                  sat_pkg::CMD_REMOVE: begin
                     ctl.res_data    = 1'b1;
                     ctl.res_status  = sat_pkg::STATUS_HIT;
                     ctl.shift_start = 1'b1;
                     state_in        = S_SHIFT;
                  end
                  default: begin
                     ctl.res_data   = 1'b1;
                     ctl.res_status = sat_pkg::STATUS_HIT;
                     state_in       = S_RESULT;
                  end
               endcase
            end else if (stat.miss) begin
               ctl.res_load = 1'b1;
               if (stat.cmd == sat_pkg::CMD_INSERT) begin
                  ctl.wr_sel     = sat_pkg::WR_APPEND;
                  ctl.count_inc  = 1'b1;
                  ctl.res_status = sat_pkg::STATUS_ADDED;
               end
               state_in = S_RESULT;
            end else begin
               ctl.scan_step = 1'b1;
            end
         end
         S_SHIFT: begin
            ctl.scan_step = 1'b1;
            if (stat.pend) begin
               ctl.wr_sel = sat_pkg::WR_SHIFT;
            end
            if (stat.shift_done) begin
               ctl.count_dec = 1'b1;
               state_in      = S_RESULT;
            end
         end
         S_READ: begin
            ctl.res_load   = 1'b1;
            ctl.res_data   = 1'b1;
            ctl.res_status = sat_pkg::STATUS_HIT;
            state_in       = S_RESULT;
         end
         S_RESULT: begin
            if (stat.out_free) begin
               ctl.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_accept_decodes: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff == S_DECODE)
      else $error("accepted word not decoded");

   a_result_waits: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_RESULT && !stat.out_free |=> state_ff == S_RESULT)
      else $error("result state left while output held");

   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("state not one-hot");

endmodule

// ===== sv/small_assoc_table_top.sv =====
`timescale 1ns / 1ps

// channel   direction  handshake            word
// req       in         req_valid/req_stall  req_word (cmd, key, value, position)
// rsp       out        rsp_valid/rsp_stall  rsp_word (status, key_out, value_out, entry_count)
//
// search commands scan the valid entries, one entry read per cycle
// from the single read port of the entry store
// remove then moves each later entry down one place, with nothing to move when the
// last entry goes; clear, full insert and read at position need no scan
// synchronous reset empties the table; the entry store itself is not cleared
// a new word is taken only while idle; a held result stalls only the final step

module small_assoc_table_top #(
   parameter int CAPACITY    = sat_pkg::CAPACITY_DEFAULT,
   parameter int KEY_WIDTH   = sat_pkg::KEY_WIDTH_DEFAULT,
   parameter int VALUE_WIDTH = sat_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  sat_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output sat_pkg::rsp_word_type rsp_word
);

   sat_pkg::ctl_cmd_type  ctl;
   sat_pkg::ctl_stat_type stat;

   sat_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .ctl       (ctl)
   );

   sat_datapath #(
      .CAPACITY    (CAPACITY),
      .KEY_WIDTH   (KEY_WIDTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .ctl       (ctl),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule
